// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module.
// No dependencies; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the asynchronous reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication shorthand built on the clocked form.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== rtl/segtree_pkg.sv =====
// Package for the segment tree range-sum block: FSM state, operation codes,
// controller command and datapath status structs. No dependencies.
package segtree_pkg;

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_QUERY  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_U_LEAF,
		ST_U_RD,
		ST_U_WR,
		ST_Q_A,
		ST_Q_B
	} state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic q_init;
		logic leaf;
		logic u_rd;
		logic u_wr;
		logic q_a;
		logic q_b;
		logic deliver;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic bad;
		logic is_query;
		logic at_root;
		logic a_lt_b;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/segtree_dp.sv =====
// Datapath of the segment tree: node-sum memory, walk indices, accumulator,
// size register and result register. Depends on segtree_pkg.
module segtree_dp
	import segtree_pkg::*;
#(
	parameter int MAX_POSITIONS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            st,
	input  logic               cfg_write_enable,
	input  logic [10:0]        cfg_write_data,
	input  logic               operation,
	input  logic [9:0]         position,
	input  logic signed [31:0] new_value,
	input  logic [9:0]         range_low,
	input  logic [9:0]         range_high,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] range_sum,
	output logic               bad_request
);

	localparam int DEPTH = 2 * MAX_POSITIONS;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);
	localparam int LW    = ($clog2(MAX_POSITIONS + 1) > 11) ? $clog2(MAX_POSITIONS + 1) : 11;

	logic [31:0]   mem [DEPTH];

	logic [10:0]   size_q;
	logic          op_q;
	logic [9:0]    pos_q;
	logic [31:0]   val_q;
	logic [9:0]    lo_q;
	logic [9:0]    hi_q;
	logic [NW-1:0] a_q;
	logic [NW-1:0] b_q;
	logic [31:0]   acc_q;
	logic [31:0]   rdata_q;
	logic          rvld_q;
	logic [AW-1:0] clr_cnt_q;

	logic [LW-1:0] size_ext;
	logic [LW-1:0] max_c;
	logic [LW-1:0] lim;
	logic          bad;
	logic [NW-1:0] leaf;
	logic [NW-1:0] a_half;
	logic [31:0]   acc_next;
	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic          re;
	logic [AW-1:0] raddr;

	assign size_ext = LW'(size_q);
	assign max_c    = LW'(MAX_POSITIONS);
	assign lim      = (size_ext > max_c) ? max_c : size_ext;
	assign bad      = (op_q == OP_QUERY) ? ((lo_q > hi_q) || (LW'(hi_q) >= lim))
	                                     : (LW'(pos_q) >= lim);
	assign leaf     = NW'(pos_q) + NW'(MAX_POSITIONS);
	assign a_half   = a_q >> 1;
	assign acc_next = acc_q + (rvld_q ? rdata_q : 32'd0);

	assign st.clr_last = (clr_cnt_q == AW'(DEPTH - 1));
	assign st.bad      = bad;
	assign st.is_query = (op_q == OP_QUERY);
	assign st.at_root  = (a_q == NW'(1));
	assign st.a_lt_b   = (a_q < b_q);
	assign st.out_free = !out_valid || out_ready;

	always_comb begin
		we    = 1'b0;
		waddr = clr_cnt_q;
		wdata = 32'd0;
		if (cmd.clr) begin
			we = 1'b1;
		end else if (cmd.leaf) begin
			we    = 1'b1;
			waddr = leaf[AW-1:0];
			wdata = val_q;
		end else if (cmd.u_wr) begin
			we    = 1'b1;
			waddr = a_half[AW-1:0];
			wdata = acc_next;
		end
	end

	always_comb begin
		re    = 1'b0;
		raddr = a_q[AW-1:0];
		if (cmd.u_rd) begin
			re    = 1'b1;
			raddr = {a_q[AW-1:1], ~a_q[0]};
		end else if (cmd.q_a) begin
			re = (a_q < b_q) && a_q[0];
		end else if (cmd.q_b) begin
			re    = b_q[0];
			raddr = {b_q[AW-1:1], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// input latch, walk indices, accumulator and result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			pos_q <= position;
			val_q <= $unsigned(new_value);
			lo_q  <= range_low;
			hi_q  <= range_high;
		end
		if (cmd.leaf) begin
			acc_q <= val_q;
			a_q   <= leaf;
		end else if (cmd.q_init) begin
			acc_q <= 32'd0;
			a_q   <= NW'(lo_q) + NW'(MAX_POSITIONS);
			b_q   <= NW'(hi_q) + NW'(MAX_POSITIONS) + NW'(1);
		end else begin
			acc_q <= acc_next;
			if (cmd.u_wr) begin
				a_q <= a_half;
			end else if (cmd.q_a) begin
				if (a_q[0]) begin
					a_q <= a_q + NW'(1);
				end
			end else if (cmd.q_b) begin
				a_q <= a_half;
				b_q <= b_q >> 1;
			end
		end
		if (cmd.deliver) begin
			range_sum <= $signed((!bad && op_q == OP_QUERY) ? acc_next : 32'd0);
			bad_request <= bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= 11'd1024;
			rvld_q    <= 1'b0;
			clr_cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_write_enable) begin
				size_q <= cfg_write_data;
			end
			rvld_q <= re;
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (cmd.deliver) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/segtree_ctrl.sv =====
// Controller FSM of the segment tree: clearing sweep, update walk and query walk.
// Depends on segtree_pkg.
module segtree_ctrl
	import segtree_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (st.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				priority if (st.bad) begin
					if (st.out_free) begin
						cmd.deliver = 1'b1;
						state_d     = ST_IDLE;
					end
				end else if (st.is_query) begin
					cmd.q_init = 1'b1;
					state_d    = ST_Q_A;
				end else begin
					state_d = ST_U_LEAF;
				end
			end
			ST_U_LEAF: begin
				cmd.leaf = 1'b1;
				state_d  = ST_U_RD;
			end
			ST_U_RD: begin
				if (st.at_root) begin
					if (st.out_free) begin
						cmd.deliver = 1'b1;
						state_d     = ST_IDLE;
					end
				end else begin
					cmd.u_rd = 1'b1;
					state_d  = ST_U_WR;
				end
			end
			ST_U_WR: begin
				cmd.u_wr = 1'b1;
				state_d  = ST_U_RD;
			end
			ST_Q_A: begin
				if (!st.a_lt_b) begin
					if (st.out_free) begin
						cmd.deliver = 1'b1;
						state_d     = ST_IDLE;
					end
				end else begin
					cmd.q_a = 1'b1;
					state_d = ST_Q_B;
				end
			end
			ST_Q_B: begin
				cmd.q_b = 1'b1;
				state_d = ST_Q_A;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/segment_tree_range_sum.sv =====
// Top level of the segment tree range-sum block: controller plus datapath.
// Depends on segtree_pkg, segtree_ctrl and segtree_dp.
//
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_ready  | operation, position, new_value, range_low/high
// out      | out_valid / out_ready| range_sum, bad_request
// cfg      | cfg_write_enable     | cfg_write_data (size_in_use)
//
// One item at a time. An update walks from the leaf up to the root, a query
// walks both range ends up the tree, and a rejected request is answered from
// the check state; the node memory read is registered. After reset a clearing
// sweep over all 2*MAX_POSITIONS node entries runs with in_ready low.
// A new item is taken while a result waits in the output register; the walk
// only holds at its last step if the previous result is still untaken.
module segment_tree_range_sum
	import segtree_pkg::*;
#(
	parameter int MAX_POSITIONS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_enable,
	input  logic [10:0]        cfg_write_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [9:0]         position,
	input  logic signed [31:0] new_value,
	input  logic [9:0]         range_low,
	input  logic [9:0]         range_high,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] range_sum,
	output logic               bad_request
);

	cmd_t    cmd;
	status_t st;

	segtree_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	segtree_dp #(
		.MAX_POSITIONS (MAX_POSITIONS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.cfg_write_enable (cfg_write_enable),
		.cfg_write_data   (cfg_write_data),
		.operation        (operation),
		.position         (position),
		.new_value        (new_value),
		.range_low        (range_low),
		.range_high       (range_high),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.range_sum        (range_sum),
		.bad_request      (bad_request)
	);

endmodule

// ===== rtl/segtree_chk.sv =====
// Port-level checker for segment_tree_range_sum, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module segtree_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] range_sum,
	input logic               bad_request
);

	`ASSERT_CLK(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(range_sum) && $stable(bad_request)), "result changed while stalled")
	`ASSERT_IMPL(a_bad_zero, clk, arst_n, out_valid && bad_request, range_sum == 32'sd0, "flagged result carries a sum")
	`ASSERT_CLK(a_one_item, clk, arst_n, (in_valid && in_ready) |=> !in_ready, "second item taken during a walk")
	`ASSERT_CLK(a_no_early, clk, arst_n, (in_valid && in_ready && !out_valid) |=> !out_valid, "result in the cycle after transfer")

endmodule

bind segment_tree_range_sum segtree_chk u_chk (.*);
